>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is applied.
`define TWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that an implication holds on the rising clock edge.
`define TWM_ASSERT_IMP(lbl, ante, cons, msg) \
    `TWM_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> hw/rtl/twm_pkg.sv
// Package with constants, types and states for the topic wildcard matcher.
`timescale 1ns / 1ps
package twm_pkg;
    localparam int MAX_LEN = 50;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int LVL_N   = MAX_LEN + 1;
    localparam int LVL_W   = $clog2(LVL_N);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TOPIC   = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    typedef struct packed {
        logic done;
        logic match;
    } res_t;

    typedef enum logic [2:0] {
        W_IDLE,
        W_T_RD,
        W_T_CHK,
        W_P_START,
        W_P_RD,
        W_P_CHK,
        W_J_END,
        W_DONE
    } wstate_t;
endpackage

>>> hw/rtl/twm_ram.sv
// Byte store with one write port and one registered read port.
`timescale 1ns / 1ps
module twm_ram (
    input  logic                      clk,
    input  twm_pkg::wr_t              wr,
    input  logic [twm_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                rdata
);
    import twm_pkg::*;

    logic [7:0] mem [MAX_LEN];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/twm_loader.sv
// String loader: tracks lengths, closed flags and effective lengths, issues writes.
`timescale 1ns / 1ps
module twm_loader (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      acc,
    input  logic                      command,
    input  logic [7:0]                ch,
    input  logic                      last,
    output twm_pkg::wr_t              pat_wr,
    output twm_pkg::wr_t              top_wr,
    output logic [twm_pkg::POS_W-1:0] pat_len,
    output logic [twm_pkg::POS_W-1:0] top_len,
    output logic                      start
);
    import twm_pkg::*;

    logic [POS_W-1:0] plen_reg, plen_next, peff_reg, peff_next;
    logic [POS_W-1:0] tlen_reg, tlen_next, teff_reg, teff_next;
    logic             pz_reg, pz_next, pclosed_reg, pclosed_next;
    logic             tz_reg, tz_next, tclosed_reg, tclosed_next;
    logic [POS_W-1:0] plen_base, peff_base, tlen_base, teff_base;
    logic             pz_base, tz_base;

    always_comb
    begin
        plen_base = pclosed_reg ? '0 : plen_reg;
        peff_base = pclosed_reg ? '0 : peff_reg;
        pz_base   = pclosed_reg ? 1'b0 : pz_reg;
        tlen_base = tclosed_reg ? '0 : tlen_reg;
        teff_base = tclosed_reg ? '0 : teff_reg;
        tz_base   = tclosed_reg ? 1'b0 : tz_reg;

        plen_next    = plen_reg;
        peff_next    = peff_reg;
        pz_next      = pz_reg;
        pclosed_next = pclosed_reg;
        tlen_next    = tlen_reg;
        teff_next    = teff_reg;
        tz_next      = tz_reg;
        tclosed_next = tclosed_reg;
        pat_wr       = '{we: 1'b0, addr: plen_base[ADDR_W-1:0], data: ch};
        top_wr       = '{we: 1'b0, addr: tlen_base[ADDR_W-1:0], data: ch};
        start        = 1'b0;

        if (acc && command == CMD_PATTERN)
        begin
            plen_next    = plen_base;
            peff_next    = peff_base;
            pz_next      = pz_base;
            pclosed_next = last;
            if (plen_base < POS_W'(MAX_LEN))
            begin
                pat_wr.we = 1'b1;
                plen_next = plen_base + POS_W'(1);
                if (!pz_base)
                begin
                    if (ch == CH_NUL)
                    begin
                        pz_next = 1'b1;
                    end
                    else
                    begin
                        peff_next = peff_base + POS_W'(1);
                    end
                end
            end
        end

        if (acc && command == CMD_TOPIC)
        begin
            tlen_next    = tlen_base;
            teff_next    = teff_base;
            tz_next      = tz_base;
            tclosed_next = last;
            start        = last;
            if (tlen_base < POS_W'(MAX_LEN))
            begin
                top_wr.we = 1'b1;
                tlen_next = tlen_base + POS_W'(1);
                if (!tz_base)
                begin
                    if (ch == CH_NUL)
                    begin
                        tz_next = 1'b1;
                    end
                    else
                    begin
                        teff_next = teff_base + POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg    <= '0;
            peff_reg    <= '0;
            pz_reg      <= 1'b0;
            pclosed_reg <= 1'b0;
            tlen_reg    <= '0;
            teff_reg    <= '0;
            tz_reg      <= 1'b0;
            tclosed_reg <= 1'b0;
        end
        else
        begin
            plen_reg    <= plen_next;
            peff_reg    <= peff_next;
            pz_reg      <= pz_next;
            pclosed_reg <= pclosed_next;
            tlen_reg    <= tlen_next;
            teff_reg    <= teff_next;
            tz_reg      <= tz_next;
            tclosed_reg <= tclosed_next;
        end
    end

    assign pat_len = peff_reg;
    assign top_len = teff_reg;
endmodule

>>> hw/rtl/twm_walker.sv
// Level walker: byte-serial compare of pattern and topic levels over a reach set.
`timescale 1ns / 1ps
module twm_walker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [twm_pkg::POS_W-1:0]  pat_len,
    input  logic [twm_pkg::POS_W-1:0]  top_len,
    input  logic [7:0]                 pdata,
    input  logic [7:0]                 tdata,
    input  logic                       out_free,
    output logic [twm_pkg::ADDR_W-1:0] praddr,
    output logic [twm_pkg::ADDR_W-1:0] traddr,
    output logic                       busy,
    output twm_pkg::res_t              res
);
    import twm_pkg::*;

    wstate_t          state_reg, state_next;
    logic [LVL_N-1:0] reach_reg, reach_next, sticky_reg, sticky_next;
    logic [LVL_N-1:0] nset_reg, nset_next;
    logic [POS_W-1:0] ts_reg, ts_next, tcur_reg, tcur_next, tpos_reg, tpos_next;
    logic [POS_W-1:0] pp_reg, pp_next, ps_reg, ps_next;
    logic [LVL_W-1:0] k_reg, k_next, kp1;
    logic [1:0]       pn_reg, pn_next;
    logic             star_reg, star_next, plus_reg, plus_next, eq_reg, eq_next;
    logic             tlast_reg, tlast_next, tend_reg, tend_next;
    logic             accept_reg, accept_next;
    logic             t_at_end, t_scan_term, p_at_end, p_term, t_term;
    logic             lvl_eq, pend, is_star, is_plus, active;

    always_comb
    begin
        t_at_end    = tcur_reg >= top_len;
        t_scan_term = t_at_end || tdata == CH_SLASH;
        p_at_end    = pp_reg >= pat_len;
        p_term      = p_at_end || pdata == CH_SLASH;
        t_term      = tpos_reg == tcur_reg;
        lvl_eq      = eq_reg && t_term;
        pend        = p_at_end && ps_reg == pat_len;
        is_star     = pn_reg == 2'd1 && star_reg;
        is_plus     = pn_reg == 2'd1 && plus_reg;
        active      = reach_reg[k_reg] || sticky_reg[k_reg];
        kp1         = k_reg + LVL_W'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            W_IDLE:    if (start) state_next = W_T_RD;
            W_T_RD:    state_next = W_T_CHK;
            W_T_CHK:   state_next = t_scan_term ? W_P_START : W_T_RD;
            W_P_START: state_next = W_P_RD;
            W_P_RD:    state_next = W_P_CHK;
            W_P_CHK:
            begin
                if (p_term)
                begin
                    state_next = p_at_end ? W_J_END : W_P_START;
                end
                else
                begin
                    state_next = W_P_RD;
                end
            end
            W_J_END:   state_next = tlast_reg ? W_DONE : W_T_RD;
            W_DONE:    if (out_free) state_next = W_IDLE;
            default:   state_next = W_IDLE;
        endcase
    end

    always_comb
    begin
        reach_next  = reach_reg;
        sticky_next = sticky_reg;
        nset_next   = nset_reg;
        ts_next     = ts_reg;
        tcur_next   = tcur_reg;
        tpos_next   = tpos_reg;
        pp_next     = pp_reg;
        ps_next     = ps_reg;
        k_next      = k_reg;
        pn_next     = pn_reg;
        star_next   = star_reg;
        plus_next   = plus_reg;
        eq_next     = eq_reg;
        tlast_next  = tlast_reg;
        tend_next   = tend_reg;
        accept_next = accept_reg;
        res         = '{done: 1'b0, match: accept_reg};
        busy        = state_reg != W_IDLE;
        praddr      = pp_reg[ADDR_W-1:0];
        traddr      = (state_reg == W_T_RD) ? tcur_reg[ADDR_W-1:0] : tpos_reg[ADDR_W-1:0];

        case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    reach_next  = LVL_N'(1);
                    sticky_next = '0;
                    accept_next = 1'b0;
                    ts_next     = '0;
                    tcur_next   = '0;
                end
            end
            W_T_CHK:
            begin
                if (t_scan_term)
                begin
                    tlast_next = t_at_end;
                    tend_next  = t_at_end && ts_reg == top_len;
                    nset_next  = '0;
                    k_next     = '0;
                    pp_next    = '0;
                end
                else
                begin
                    tcur_next = tcur_reg + POS_W'(1);
                end
            end
            W_P_START:
            begin
                ps_next   = pp_reg;
                pn_next   = 2'd0;
                eq_next   = 1'b1;
                star_next = 1'b0;
                plus_next = 1'b0;
                tpos_next = ts_reg;
            end
            W_P_CHK:
            begin
                if (!p_term)
                begin
                    if (pn_reg == 2'd0)
                    begin
                        star_next = pdata == CH_STAR;
                        plus_next = pdata == CH_PLUS;
                    end
                    if (pn_reg != 2'd2)
                    begin
                        pn_next = pn_reg + 2'd1;
                    end
                    if (t_term || pdata != tdata)
                    begin
                        eq_next = 1'b0;
                    end
                    pp_next = pp_reg + POS_W'(1);
                    if (!t_term)
                    begin
                        tpos_next = tpos_reg + POS_W'(1);
                    end
                end
                else
                begin
                    if (active)
                    begin
                        if (pend)
                        begin
                            if (tend_reg)
                            begin
                                accept_next = 1'b1;
                            end
                        end
                        else if (!tend_reg)
                        begin
                            if (is_star)
                            begin
                                if (p_at_end)
                                begin
                                    accept_next = 1'b1;
                                end
                                else
                                begin
                                    reach_next[kp1]  = 1'b1;
                                    sticky_next[kp1] = 1'b1;
                                end
                            end
                            else if (is_plus || lvl_eq)
                            begin
                                if (p_at_end && tlast_reg)
                                begin
                                    accept_next = 1'b1;
                                end
                                else if (!p_at_end && !tlast_reg)
                                begin
                                    nset_next[kp1] = 1'b1;
                                end
                            end
                        end
                    end
                    if (!p_at_end)
                    begin
                        pp_next = pp_reg + POS_W'(1);
                        k_next  = kp1;
                    end
                end
            end
            W_J_END:
            begin
                if (!tlast_reg)
                begin
                    reach_next = nset_reg;
                    ts_next    = tcur_reg + POS_W'(1);
                    tcur_next  = tcur_reg + POS_W'(1);
                end
            end
            W_DONE:
            begin
                res.done = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= W_IDLE;
            reach_reg  <= '0;
            sticky_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            reach_reg  <= reach_next;
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nset_reg   <= nset_next;
        ts_reg     <= ts_next;
        tcur_reg   <= tcur_next;
        tpos_reg   <= tpos_next;
        pp_reg     <= pp_next;
        ps_reg     <= ps_next;
        k_reg      <= k_next;
        pn_reg     <= pn_next;
        star_reg   <= star_next;
        plus_reg   <= plus_next;
        eq_reg     <= eq_next;
        tlast_reg  <= tlast_next;
        tend_reg   <= tend_next;
        accept_reg <= accept_next;
    end
endmodule

>>> hw/rtl/topic_wildcard_matcher.sv
// A pattern byte or a non-final topic byte is taken and stored, with no result.
// A final topic byte starts a walk: per topic level the walker scans the topic bytes,
// then, for each pattern level, reads and compares its bytes, then closes the level.
// The result is registered when the walk ends; a stalled result holds the walker.
// Input is stalled from the final topic byte until the result register is loaded.
// Reset clears lengths, flags, reach set and result valid; store contents stay undefined.
`timescale 1ns / 1ps
module topic_wildcard_matcher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       command,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       matched
);
    import twm_pkg::*;

    wr_t              pat_wr, top_wr;
    logic [POS_W-1:0] pat_len, top_len;
    logic [ADDR_W-1:0] praddr, traddr;
    logic [7:0]       pdata, tdata;
    logic             start, busy, acc, out_free;
    res_t             res;
    logic             rv_reg, rv_next, matched_reg;

    assign item_stall = busy;
    assign acc        = item_valid && !busy;
    assign out_free   = !rv_reg || !result_stall;

    twm_loader u_loader (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc     (acc),
        .command (command),
        .ch      (ch),
        .last    (last),
        .pat_wr  (pat_wr),
        .top_wr  (top_wr),
        .pat_len (pat_len),
        .top_len (top_len),
        .start   (start)
    );

    twm_ram u_pat_ram (
        .clk   (clk),
        .wr    (pat_wr),
        .raddr (praddr),
        .rdata (pdata)
    );

    twm_ram u_top_ram (
        .clk   (clk),
        .wr    (top_wr),
        .raddr (traddr),
        .rdata (tdata)
    );

    twm_walker u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .pat_len  (pat_len),
        .top_len  (top_len),
        .pdata    (pdata),
        .tdata    (tdata),
        .out_free (out_free),
        .praddr   (praddr),
        .traddr   (traddr),
        .busy     (busy),
        .res      (res)
    );

    always_comb
    begin
        rv_next = res.done || (rv_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            matched_reg <= res.match;
        end
    end

    assign result_valid = rv_reg;
    assign matched      = matched_reg;
endmodule

>>> hw/rtl/twm_checker.sv
// Port checker for the topic wildcard matcher and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module twm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic       command,
    input logic [7:0] ch,
    input logic       last,
    input logic       result_valid,
    input logic       result_stall,
    input logic       matched
);
    import twm_pkg::*;

    `TWM_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(matched), "stalled result transaction changed")
    `TWM_ASSERT(a_busy_after_topic, item_valid && !item_stall && command == CMD_TOPIC && last |=> item_stall, "input not stalled after final topic byte")
    `TWM_ASSERT(a_no_result_after_pattern, item_valid && !item_stall && command == CMD_PATTERN |=> !$rose(result_valid), "result raised right after a pattern byte")
    `TWM_ASSERT_IMP(a_no_result_on_load, $rose(result_valid), $past(item_stall), "result raised while input was open")
endmodule

bind topic_wildcard_matcher twm_checker u_twm_checker (.*);

>>> tb/sv/tb_topic_wildcard_matcher.sv
// Self-checking testbench for topic_wildcard_matcher: directed strings, then random traffic.
`timescale 1ns / 1ps
module tb_topic_wildcard_matcher;
    import twm_pkg::*;

    typedef struct {
        logic       cmd;
        logic [7:0] chr;
        logic       fin;
        int         typed;
        bit         drain;
    } byte_txn_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    logic       command;
    logic [7:0] ch;
    logic       last;
    logic       result_valid;
    logic       result_stall;
    logic       matched;

    byte_txn_t  txn_q[$];
    bit         match_q[$];
    int         mismatches;
    int         failures;
    int         idle_pct;

    logic [7:0] pat_mem[MAX_LEN];
    logic [7:0] top_mem[MAX_LEN];
    int         pat_cnt;
    int         top_cnt;
    bit         pat_done;
    bit         top_done;

    string      dir_str[16];
    int         dir_kind[16];
    int         dir_exp[16];

    topic_wildcard_matcher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .ch           (ch),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .matched      (matched)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #1s;
        $display("topic_wildcard_matcher verification failed");
        $finish;
    end

    function automatic int text_len(ref logic [7:0] mem[MAX_LEN], input int n);
        int i;
        for (i = 0; i < n && i < MAX_LEN; i++)
            if (mem[i] == CH_NUL)
                return i;
        return (n < MAX_LEN) ? n : MAX_LEN;
    endfunction

    function automatic int split(ref logic [7:0] mem[MAX_LEN], input int n,
                                 ref int st[LVL_N], ref int ln[LVL_N]);
        int cnt;
        int b;
        int i;
        cnt = 0;
        b = 0;
        for (i = 0; i < n; i++)
            if (mem[i] == CH_SLASH)
            begin
                st[cnt] = b;
                ln[cnt] = i - b;
                cnt++;
                b = i + 1;
            end
        st[cnt] = b;
        ln[cnt] = n - b;
        return cnt + 1;
    endfunction

    function automatic bit topic_matches();
        int pl, tl, m, n, j, k, i, ps, pn;
        int pst[LVL_N], pln[LVL_N], tst[LVL_N], tln[LVL_N];
        bit reach[LVL_N], sticky[LVL_N], nxt[LVL_N];
        bit tlast, tend, plast, pend, hit, acc;
        pl = text_len(pat_mem, pat_cnt);
        tl = text_len(top_mem, top_cnt);
        m = split(pat_mem, pl, pst, pln);
        n = split(top_mem, tl, tst, tln);
        acc = 0;
        for (k = 0; k < LVL_N; k++)
        begin
            reach[k] = 0;
            sticky[k] = 0;
        end
        reach[0] = 1;
        for (j = 0; j < n; j++)
        begin
            tlast = (j == n - 1);
            tend = tlast && (tst[j] == tl);
            for (k = 0; k < LVL_N; k++)
                nxt[k] = 0;
            for (k = 0; k < m; k++)
            begin
                plast = (k == m - 1);
                pend = plast && (pst[k] == pl);
                ps = pst[k];
                pn = pln[k];
                if (!(reach[k] || sticky[k]))
                    continue;
                if (pend)
                begin
                    if (tend)
                        acc = 1;
                    continue;
                end
                if (tend)
                    continue;
                if (pn == 1 && pat_mem[ps] == CH_STAR)
                begin
                    if (plast)
                        acc = 1;
                    else
                    begin
                        reach[k + 1] = 1;
                        sticky[k + 1] = 1;
                    end
                    continue;
                end
                hit = (pn == 1 && pat_mem[ps] == CH_PLUS);
                if (!hit && pn == tln[j])
                begin
                    hit = 1;
                    for (i = 0; i < pn; i++)
                        if (pat_mem[ps + i] != top_mem[tst[j] + i])
                            hit = 0;
                end
                if (hit)
                begin
                    if (plast && tlast)
                        acc = 1;
                    else if (!plast && !tlast)
                        nxt[k + 1] = 1;
                end
            end
            if (!tlast)
                reach = nxt;
        end
        return acc;
    endfunction

    task automatic absorb(input byte_txn_t t);
        if (t.cmd == CMD_PATTERN)
        begin
            if (pat_done)
            begin
                pat_cnt = 0;
                pat_done = 0;
            end
            if (pat_cnt < MAX_LEN)
            begin
                pat_mem[pat_cnt] = t.chr;
                pat_cnt++;
            end
            if (t.fin)
                pat_done = 1;
        end
        else
        begin
            if (top_done)
            begin
                top_cnt = 0;
                top_done = 0;
            end
            if (top_cnt < MAX_LEN)
            begin
                top_mem[top_cnt] = t.chr;
                top_cnt++;
            end
            if (t.fin)
            begin
                top_done = 1;
                if (t.typed >= 0)
                    match_q.push_back(t.typed[0]);
                else
                    match_q.push_back(topic_matches());
            end
        end
    endtask

    task automatic queue_string(input logic cmd, input logic [7:0] s[$], input bit fin,
                                input int typed, input bit drain);
        byte_txn_t t;
        int i;
        if (s.size() == 0)
            s.push_back(CH_NUL);
        for (i = 0; i < s.size(); i++)
        begin
            t.cmd = cmd;
            t.chr = s[i];
            t.fin = fin && (i == s.size() - 1);
            t.typed = t.fin ? typed : -1;
            t.drain = drain && (i == 0);
            txn_q.push_back(t);
        end
    endtask

    task automatic random_levels(input bit pat, output logic [7:0] s[$]);
        int n, i, sel;
        string tok;
        s = {};
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
        begin
            if (i > 0)
                s.push_back(CH_SLASH);
            sel = $urandom_range(0, pat ? 6 : 4);
            case (sel)
                0: tok = "a";
                1: tok = "b";
                2: tok = "ab";
                3: tok = "";
                4: tok = "ba";
                5: tok = "+";
                default: tok = "*";
            endcase
            foreach (tok[k])
                s.push_back(tok[k]);
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            absorb('{command, ch, last, -1, 0});
        if (rst_n && result_valid && !result_stall)
        begin
            if (match_q.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected result matched=%0b", matched);
                mismatches++;
            end
            else if (matched !== match_q[0])
            begin
                failures++;
                if (mismatches < 10)
                    $display("matched mismatch: expected %0b actual %0b", match_q[0], matched);
                mismatches++;
                void'(match_q.pop_front());
            end
            else
                void'(match_q.pop_front());
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    initial
    begin
        logic [7:0] s[$];
        byte_txn_t t;
        int i, k, n, kind;
        item_valid = 1'b0;
        command = CMD_PATTERN;
        ch = CH_NUL;
        last = 1'b0;
        rst_n = 1'b0;
        mismatches = 0;
        failures = 0;
        idle_pct = 30;
        pat_cnt = 0;
        top_cnt = 0;
        pat_done = 0;
        top_done = 0;

        dir_kind = '{0, 1, 0, 1, 1, 0, 1, 1, 0, 1, 0, 1, 2, 1, 0, 1};
        dir_str = '{"", "", "a/+/b", "a/x/b", "a/b", "a/*", "a/b/c", "a",
                    "*/b", "x/y/b", "a~b", "a^", "+/c", "q/c", "", "+"};
        dir_exp = '{-1, 1, -1, 1, 0, -1, 1, -1, -1, -1, -1, -1, -1, -1, -1, -1};
        dir_str[14] = "";
        for (i = 0; i < 60; i++)
            dir_str[14] = {dir_str[14], "z"};
        for (i = 0; i < 16; i++)
        begin
            s = {};
            for (k = 0; k < dir_str[i].len(); k++)
                s.push_back(dir_str[i][k] == "~" ? 8'h00 :
                            dir_str[i][k] == "^" ? 8'hFF : dir_str[i][k]);
            queue_string(dir_kind[i] == 1 ? CMD_TOPIC : CMD_PATTERN, s,
                         dir_kind[i] != 2, dir_exp[i], 0);
        end
        queue_string(CMD_TOPIC, s, 1, -1, 1);

        while (txn_q.size() < 1850)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                if ($urandom_range(0, 1))
                begin
                    random_levels(1, s);
                    queue_string(CMD_PATTERN, s, 1, -1, 0);
                end
                random_levels(0, s);
                queue_string(CMD_TOPIC, s, 1, -1, 0);
            end
            else
            begin
                s = {};
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(45, 60) : $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    s.push_back($urandom_range(0, 3) == 0 ? CH_SLASH :
                                8'($urandom_range(0, 255)));
                queue_string(1'($urandom_range(0, 1)), s, $urandom_range(0, 3) != 0, -1,
                             $urandom_range(0, 40) == 0);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < txn_q.size(); i++)
        begin
            t = txn_q[i];
            idle_pct <= (i > 900 && i < 1150) ? 0 : 30;
            if (t.drain)
            begin
                item_valid <= 1'b0;
                while (match_q.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            if (i < 900 || i >= 1150)
                while ($urandom_range(0, 99) < 30)
                begin
                    item_valid <= 1'b0;
                    @(posedge clk);
                end
            item_valid <= 1'b1;
            command <= t.cmd;
            ch <= t.chr;
            last <= t.fin;
            @(negedge clk);
            while (item_stall)
                @(negedge clk);
            @(posedge clk);
        end
        item_valid <= 1'b0;
        while (match_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (failures == 0 && match_q.size() == 0)
            $display("topic_wildcard_matcher verification clean");
        else
            $display("topic_wildcard_matcher verification failed");
        $finish;
    end
endmodule
